// ----- rtl/core/window_capped_distinct_count_unit_macros.svh -----
// Assertion helpers for the distinct-count unit.
// Both sample on clk and are disabled while arst_n is low.
`ifndef WINDOW_CAPPED_DISTINCT_COUNT_UNIT_MACROS_SVH
`define WINDOW_CAPPED_DISTINCT_COUNT_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WCDC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WCDC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define WCDC_ASSERT_NOW(name, ante, cons, msg)

`define WCDC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- rtl/core/wcdc_pkg.sv -----
`timescale 1ns / 1ps

package wcdc_pkg;

	localparam int POS_W   = 10;
	localparam int VAL_W   = 10;
	localparam int CNT_W   = 11;
	localparam int LIMIT_W = 11;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);

	localparam int ARRAY_DEPTH_DEF = 1024;
	localparam int VALUE_RANGE_DEF = 1024;

	// command queue between front and back
	localparam int FQ_DEPTH = 2;
	localparam int FQ_AW    = $clog2(FQ_DEPTH);

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef enum logic [1:0] {
		CMD_LOAD  = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_DRAIN = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [POS_W-1:0]   left;   // load position or query left bound
		logic [POS_W-1:0]   right;
		logic [VAL_W-1:0]   val;
	} cmd_t;

endpackage

// ----- rtl/core/wcdc_ram.sv -----
`timescale 1ns / 1ps

module wcdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/wcdc_front.sv -----
`timescale 1ns / 1ps

module wcdc_front #(
	parameter int ARRAY_DEPTH = wcdc_pkg::ARRAY_DEPTH_DEF,
	parameter int VALUE_RANGE = wcdc_pkg::VALUE_RANGE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      mode,
	input  logic [wcdc_pkg::POS_W-1:0] position,
	input  logic [wcdc_pkg::POS_W-1:0] right_bound,
	input  logic [wcdc_pkg::VAL_W-1:0] value_code,
	input  logic                      clear_busy,
	output logic                      cmd_valid,
	input  logic                      cmd_ready,
	output wcdc_pkg::cmd_t            cmd
);
	import wcdc_pkg::*;

	logic [31:0]      pos32, rb32, val32, last_pos;
	logic [POS_W-1:0] pos_sat, rb_sat;
	logic             load_ok, accept, enq, deq;
	cmd_t             new_cmd;

	cmd_t             fq_q [FQ_DEPTH];
	logic [FQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FQ_AW:0]   fill_q;

	assign pos32    = 32'(position);
	assign rb32     = 32'(right_bound);
	assign val32    = 32'(value_code);
	assign last_pos = 32'(ARRAY_DEPTH - 1);

	// bounds past the array end clamp to the last entry
	assign pos_sat = (pos32 >= 32'(ARRAY_DEPTH)) ? last_pos[POS_W-1:0] : position;
	assign rb_sat  = (rb32 >= 32'(ARRAY_DEPTH)) ? last_pos[POS_W-1:0] : right_bound;
	assign load_ok = (pos32 < 32'(ARRAY_DEPTH)) && (val32 < 32'(VALUE_RANGE));

	always_comb begin
		new_cmd       = '0;
		new_cmd.left  = pos_sat;
		new_cmd.right = rb_sat;
		new_cmd.val   = value_code;
		if (mode == MODE_LOAD) begin
			new_cmd.kind = CMD_LOAD;
			new_cmd.left = position;
		end else if (pos_sat > rb_sat) begin
			new_cmd.kind = CMD_DRAIN;
		end else begin
			new_cmd.kind = CMD_QUERY;
		end
	end

	assign full      = (fill_q == (FQ_AW + 1)'(FQ_DEPTH)) || clear_busy;
	assign accept    = push && !full;
	// out-of-range loads are dropped here
	assign enq       = accept && ((mode == MODE_QUERY) || load_ok);
	assign cmd_valid = (fill_q != '0);
	assign deq       = cmd_valid && cmd_ready;
	assign cmd       = fq_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + FQ_AW'(1);
			end
			if (deq) begin
				rd_ptr_q <= rd_ptr_q + FQ_AW'(1);
			end
			case ({enq, deq})
				2'b10:   fill_q <= fill_q + (FQ_AW + 1)'(1);
				2'b01:   fill_q <= fill_q - (FQ_AW + 1)'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			fq_q[wr_ptr_q] <= new_cmd;
		end
	end

endmodule

// ----- rtl/core/wcdc_back.sv -----
`timescale 1ns / 1ps

module wcdc_back #(
	parameter int ARRAY_DEPTH = wcdc_pkg::ARRAY_DEPTH_DEF,
	parameter int VALUE_RANGE = wcdc_pkg::VALUE_RANGE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wcdc_pkg::LIMIT_W-1:0] max_multiplicity,
	input  logic                        cmd_valid,
	output logic                        cmd_ready,
	input  wcdc_pkg::cmd_t              cmd,
	output logic                        clear_busy,
	output logic                        empty,
	input  logic                        pop,
	output logic [wcdc_pkg::CNT_W-1:0]  count
);
	import wcdc_pkg::*;

	localparam int AW = $clog2(ARRAY_DEPTH);
	localparam int VW = $clog2(VALUE_RANGE);
	localparam int HW = $clog2(ARRAY_DEPTH + 1);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_PLAN  = 5'b00100,
		S_VWAIT = 5'b01000,
		S_HWAIT = 5'b10000
	} state_t;

	typedef enum logic [3:0] {
		LD_START = 4'b0001,
		LD_WRITE = 4'b0010,
		LD_ADD   = 4'b0100,
		LD_DONE  = 4'b1000
	} ld_phase_t;

	state_t            state_q;
	ld_phase_t         ld_phase_q, ld_next;
	cmd_t              cmd_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]  run_cnt_q, cnt_next;
	logic [POS_W-1:0]  win_left_q, win_right_q, nl, nr;
	logic              win_empty_q, ne;
	logic              step_add_q;
	logic [VW-1:0]     v_q, clr_idx_q;
	logic              out_valid_q;
	logic [CNT_W-1:0]  out_cnt_q;

	// plan decode
	logic             step_go, step_add, load_done, finish, res_zero, in_win, out_free;
	logic             res_fire;
	logic [POS_W-1:0] step_idx;
	logic             vs_we;

	// ram ports
	logic [31:0]   step_idx32, ld_idx32, val32;
	logic [AW-1:0] vs_raddr, vs_waddr;
	logic [VW-1:0] vs_wdata, vs_rdata;
	logic          h_we;
	logic [VW-1:0] h_waddr;
	logic [HW-1:0] h_wdata, h_rdata, h_new;
	logic          inc, dec;
	logic [31:0]   lim32;

	assign out_free = !out_valid_q || pop;
	assign in_win   = !win_empty_q && (cmd_q.left >= win_left_q)
		&& (cmd_q.left <= win_right_q);

	always_comb begin
		step_go   = 1'b0;
		step_add  = 1'b0;
		step_idx  = win_left_q;
		load_done = 1'b0;
		finish    = 1'b0;
		res_zero  = 1'b0;
		vs_we     = 1'b0;
		nl        = win_left_q;
		nr        = win_right_q;
		ne        = win_empty_q;
		ld_next   = ld_phase_q;
		if (state_q == S_PLAN) begin
			case (cmd_q.kind)
				CMD_LOAD: begin
					case (ld_phase_q)
						LD_START: begin
							if (in_win) begin
								// take the old value out first
								step_go  = 1'b1;
								step_idx = cmd_q.left;
								ld_next  = LD_WRITE;
							end else begin
								vs_we     = 1'b1;
								load_done = 1'b1;
							end
						end
						LD_WRITE: begin
							vs_we   = 1'b1;
							ld_next = LD_ADD;
						end
						LD_ADD: begin
							step_go  = 1'b1;
							step_add = 1'b1;
							step_idx = cmd_q.left;
							ld_next  = LD_DONE;
						end
						default: load_done = 1'b1;
					endcase
				end
				CMD_QUERY: begin
					// grow right, grow left, shrink right, shrink left
					if (win_empty_q) begin
						step_go  = 1'b1;
						step_add = 1'b1;
						step_idx = cmd_q.left;
						nl       = cmd_q.left;
						nr       = cmd_q.left;
						ne       = 1'b0;
					end else if (win_right_q < cmd_q.right) begin
						step_go  = 1'b1;
						step_add = 1'b1;
						step_idx = win_right_q + POS_W'(1);
						nr       = step_idx;
					end else if (win_left_q > cmd_q.left) begin
						step_go  = 1'b1;
						step_add = 1'b1;
						step_idx = win_left_q - POS_W'(1);
						nl       = step_idx;
					end else if (win_right_q > cmd_q.right) begin
						step_go  = 1'b1;
						step_idx = win_right_q;
						nr       = win_right_q - POS_W'(1);
					end else if (win_left_q < cmd_q.left) begin
						step_go  = 1'b1;
						step_idx = win_left_q;
						nl       = win_left_q + POS_W'(1);
					end else begin
						finish = 1'b1;
					end
				end
				CMD_DRAIN: begin
					// walk the window out, left to right
					if (win_empty_q) begin
						finish   = 1'b1;
						res_zero = 1'b1;
						nl       = '0;
						nr       = '0;
					end else begin
						step_go  = 1'b1;
						step_idx = win_left_q;
						if (win_left_q == win_right_q) begin
							ne = 1'b1;
						end else begin
							nl = win_left_q + POS_W'(1);
						end
					end
				end
				default: load_done = 1'b1;
			endcase
		end
	end

	assign res_fire = (state_q == S_PLAN) && finish && out_free;

	assign step_idx32 = 32'(step_idx);
	assign ld_idx32   = 32'(cmd_q.left);
	assign val32      = 32'(cmd_q.val);
	assign vs_raddr   = step_idx32[AW-1:0];
	assign vs_waddr   = ld_idx32[AW-1:0];
	assign vs_wdata   = val32[VW-1:0];

	wcdc_ram #(
		.WIDTH(VW),
		.DEPTH(ARRAY_DEPTH)
	) u_value_store (
		.clk  (clk),
		.we   (vs_we),
		.waddr(vs_waddr),
		.wdata(vs_wdata),
		.raddr(vs_raddr),
		.rdata(vs_rdata)
	);

	// histogram read-modify-write
	assign lim32 = 32'(limit_q);

	always_comb begin
		h_new = h_rdata;
		inc   = 1'b0;
		dec   = 1'b0;
		if (step_add_q) begin
			h_new = h_rdata + HW'(1);
			inc   = (h_new == HW'(1));
			dec   = (32'(h_new) == lim32 + 32'd1);
		end else if (h_rdata != '0) begin
			h_new = h_rdata - HW'(1);
			dec   = (h_new == '0);
			inc   = (32'(h_new) == lim32);
		end
	end

	assign cnt_next = run_cnt_q + CNT_W'(inc) - CNT_W'(dec);

	assign h_we    = (state_q == S_CLEAR) || (state_q == S_HWAIT);
	assign h_waddr = (state_q == S_CLEAR) ? clr_idx_q : v_q;
	assign h_wdata = (state_q == S_CLEAR) ? '0 : h_new;

	wcdc_ram #(
		.WIDTH(HW),
		.DEPTH(VALUE_RANGE)
	) u_histogram (
		.clk  (clk),
		.we   (h_we),
		.waddr(h_waddr),
		.wdata(h_wdata),
		.raddr(vs_rdata),
		.rdata(h_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ld_phase_q  <= LD_START;
			limit_q     <= LIMIT_RESET;
			run_cnt_q   <= '0;
			win_left_q  <= '0;
			win_right_q <= '0;
			win_empty_q <= 1'b1;
			step_add_q  <= 1'b0;
			clr_idx_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (pop && out_valid_q) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_idx_q <= clr_idx_q + VW'(1);
					if (clr_idx_q == VW'(VALUE_RANGE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cfg_valid) begin
						limit_q     <= max_multiplicity;
						run_cnt_q   <= '0;
						win_left_q  <= '0;
						win_right_q <= '0;
						win_empty_q <= 1'b1;
						clr_idx_q   <= '0;
						state_q     <= S_CLEAR;
					end else if (cmd_valid) begin
						ld_phase_q <= LD_START;
						state_q    <= S_PLAN;
					end
				end
				S_PLAN: begin
					win_left_q  <= nl;
					win_right_q <= nr;
					win_empty_q <= ne;
					ld_phase_q  <= ld_next;
					if (step_go) begin
						step_add_q <= step_add;
						state_q    <= S_VWAIT;
					end else if (load_done || res_fire) begin
						state_q <= S_IDLE;
					end
					if (res_fire && res_zero) begin
						run_cnt_q <= '0;
					end
				end
				S_VWAIT: begin
					state_q <= S_HWAIT;
				end
				S_HWAIT: begin
					run_cnt_q <= cnt_next;
					state_q   <= S_PLAN;
				end
				default: begin
					clr_idx_q <= '0;
					state_q   <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_IDLE) && cmd_valid && !cfg_valid) begin
			cmd_q <= cmd;
		end
		if (state_q == S_VWAIT) begin
			v_q <= vs_rdata;
		end
		if (res_fire) begin
			out_cnt_q <= res_zero ? '0 : run_cnt_q;
		end
	end

	assign cfg_ready  = (state_q == S_IDLE);
	assign cmd_ready  = (state_q == S_IDLE) && !cfg_valid;
	assign clear_busy = (state_q == S_CLEAR);
	assign empty      = !out_valid_q;
	assign count      = out_cnt_q;

endmodule

// ----- rtl/core/window_capped_distinct_count_unit.sv -----
`timescale 1ns / 1ps
// Channel   | Handshake                        | Payload
// ----------+----------------------------------+-----------------------------------------
// input     | push / full                      | mode, position, right_bound, value_code
// result    | empty / pop                      | count
// config    | cfg_valid / cfg_ready            | max_multiplicity
//
// A load outside the window only writes the value store; one inside it first takes the
// old value out, then writes and adds the new one. A query moves the window one element
// at a time; each element is one value-store read, one histogram read and one histogram
// write, done in turn. Reset and every config beat run a histogram clearing pass; full
// stays high for its length. A two-beat command queue lets input beats land while the
// back end walks or while a result waits on pop.
`include "window_capped_distinct_count_unit_macros.svh"

module window_capped_distinct_count_unit #(
	parameter int ARRAY_DEPTH = wcdc_pkg::ARRAY_DEPTH_DEF,
	parameter int VALUE_RANGE = wcdc_pkg::VALUE_RANGE_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	output logic                        full,
	input  logic                        mode,
	input  logic [wcdc_pkg::POS_W-1:0]   position,
	input  logic [wcdc_pkg::POS_W-1:0]   right_bound,
	input  logic [wcdc_pkg::VAL_W-1:0]   value_code,
	output logic                        empty,
	input  logic                        pop,
	output logic [wcdc_pkg::CNT_W-1:0]   count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [wcdc_pkg::LIMIT_W-1:0] max_multiplicity
);
	import wcdc_pkg::*;

	logic cmd_valid, cmd_ready, clear_busy;
	cmd_t cmd;

	wcdc_front #(
		.ARRAY_DEPTH(ARRAY_DEPTH),
		.VALUE_RANGE(VALUE_RANGE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.mode       (mode),
		.position   (position),
		.right_bound(right_bound),
		.value_code (value_code),
		.clear_busy (clear_busy),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd        (cmd)
	);

	wcdc_back #(
		.ARRAY_DEPTH(ARRAY_DEPTH),
		.VALUE_RANGE(VALUE_RANGE)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.max_multiplicity(max_multiplicity),
		.cmd_valid       (cmd_valid),
		.cmd_ready       (cmd_ready),
		.cmd             (cmd),
		.clear_busy      (clear_busy),
		.empty           (empty),
		.pop             (pop),
		.count           (count)
	);

	// no input beat may land while the histogram is being cleared
	`WCDC_ASSERT_NOW(a_full_while_clearing, clear_busy, full, "input open during clear")
	// a command handed to the back end leaves it busy in the cycle after
	`WCDC_ASSERT_NEXT(a_cmd_starts_work, cmd_valid && cmd_ready, !cmd_ready, "back end re-took")
	// a config beat always starts a clearing pass
	`WCDC_ASSERT_NEXT(a_cfg_clears, cfg_valid && cfg_ready, clear_busy, "config without clear")

endmodule

// ----- sim/window_capped_distinct_count_unit_tb.sv -----
`timescale 1ns / 1ps

module window_capped_distinct_count_unit_tb;
	import wcdc_pkg::*;

	localparam int DEPTH = ARRAY_DEPTH_DEF;
	localparam int SPAN = VALUE_RANGE_DEF;
	localparam int GAP_PCT = 14;
	localparam int STALL_LIMIT = 40000;
	localparam int SETTLE_CYCLES = 64;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 150;
	localparam int STEADY_PHASE = 4;
	localparam logic FIXED = 1'b1;
	localparam logic MODELED = 1'b0;

	typedef struct packed {
		logic             mode;
		logic [POS_W-1:0] pos;
		logic [POS_W-1:0] rb;
		logic [VAL_W-1:0] val;
	} beat_t;

	typedef struct packed {
		beat_t            beat;
		logic             fixed;
		logic [CNT_W-1:0] want;
	} row_t;

	localparam int ROW_COUNT = 24;

	// limit 1 throughout; fixed counts follow by hand from the window contents
	localparam row_t ROWS [ROW_COUNT] = '{
		'{'{MODE_QUERY, 10'd5,    10'd2,    10'd0},    FIXED,   11'd0},
		'{'{MODE_QUERY, 10'd1023, 10'd0,    10'd0},    FIXED,   11'd0},
		'{'{MODE_LOAD,  10'd0,    10'd1023, 10'd0},    MODELED, 11'd0},
		'{'{MODE_LOAD,  10'd1,    10'd0,    10'd1023}, MODELED, 11'd0},
		'{'{MODE_LOAD,  10'd2,    10'd0,    10'd0},    MODELED, 11'd0},
		'{'{MODE_LOAD,  10'd3,    10'd0,    10'd1023}, MODELED, 11'd0},
		'{'{MODE_LOAD,  10'd4,    10'd0,    10'd7},    MODELED, 11'd0},
		'{'{MODE_QUERY, 10'd0,    10'd0,    10'd1023}, FIXED,   11'd1},
		'{'{MODE_QUERY, 10'd0,    10'd2,    10'd0},    FIXED,   11'd1},
		'{'{MODE_QUERY, 10'd0,    10'd4,    10'd0},    FIXED,   11'd1},
		'{'{MODE_QUERY, 10'd3,    10'd4,    10'd0},    FIXED,   11'd2},
		'{'{MODE_QUERY, 10'd1,    10'd3,    10'd0},    MODELED, 11'd0},
		'{'{MODE_LOAD,  10'd2,    10'd0,    10'd5},    MODELED, 11'd0},
		'{'{MODE_QUERY, 10'd1,    10'd3,    10'd0},    FIXED,   11'd1},
		'{'{MODE_LOAD,  10'd1023, 10'd0,    10'd1023}, MODELED, 11'd0},
		'{'{MODE_LOAD,  10'd1022, 10'd0,    10'd0},    MODELED, 11'd0},
		'{'{MODE_QUERY, 10'd4,    10'd3,    10'd0},    FIXED,   11'd0},
		'{'{MODE_QUERY, 10'd1022, 10'd1023, 10'd0},    FIXED,   11'd2},
		'{'{MODE_QUERY, 10'd1023, 10'd1023, 10'd0},    FIXED,   11'd1},
		'{'{MODE_LOAD,  10'd1023, 10'd0,    10'd0},    MODELED, 11'd0},
		'{'{MODE_QUERY, 10'd1022, 10'd1023, 10'd0},    FIXED,   11'd0},
		'{'{MODE_QUERY, 10'd1023, 10'd1022, 10'd0},    FIXED,   11'd0},
		'{'{MODE_LOAD,  10'd512,  10'd0,    10'd1023}, MODELED, 11'd0},
		'{'{MODE_QUERY, 10'd512,  10'd512,  10'd0},    FIXED,   11'd1}
	};

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic               mode;
	logic [POS_W-1:0]   position;
	logic [POS_W-1:0]   right_bound;
	logic [VAL_W-1:0]   value_code;
	logic               empty;
	logic               pop;
	logic [CNT_W-1:0]   count;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [LIMIT_W-1:0] max_multiplicity;

	window_capped_distinct_count_unit dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.mode             (mode),
		.position         (position),
		.right_bound      (right_bound),
		.value_code       (value_code),
		.empty            (empty),
		.pop              (pop),
		.count            (count),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.max_multiplicity (max_multiplicity)
	);

	// shadow of the block state
	logic [VAL_W-1:0] stored_val [DEPTH];
	bit               written [DEPTH];
	int unsigned      hist [SPAN];
	int unsigned      cap;
	int unsigned      win_lo;
	int unsigned      win_hi;
	int unsigned      live;
	bit               win_void;

	logic [CNT_W-1:0] counts_due [$];
	logic [CNT_W-1:0] due_count;
	logic [LIMIT_W-1:0] lim_seq [PHASES];
	int               errors;
	int               stall;
	bit               steady;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(string msg);
		$display("mismatch at %0t: %s", $time, msg);
		errors++;
	endtask

	function automatic void window_clear();
		foreach (hist[i])
			hist[i] = 0;
		live = 0;
		win_void = 1'b1;
		win_lo = 0;
		win_hi = 0;
	endfunction

	function automatic void tally_add(int unsigned idx);
		int unsigned v;
		v = stored_val[idx];
		hist[v]++;
		if (hist[v] == 1)
			live++;
		if (hist[v] == cap + 1)
			live--;
	endfunction

	function automatic void tally_drop(int unsigned idx);
		int unsigned v;
		v = stored_val[idx];
		if (hist[v] == 0)
			return;
		hist[v]--;
		if (hist[v] == 0)
			live--;
		if (hist[v] == cap)
			live++;
	endfunction

	function automatic bit predict_count(beat_t b, output logic [CNT_W-1:0] res);
		int unsigned l;
		int unsigned r;
		int unsigned j;
		bit in_win;
		res = '0;
		l = b.pos;
		r = b.rb;
		if (b.mode == MODE_LOAD) begin
			in_win = !win_void && l >= win_lo && l <= win_hi;
			if (in_win)
				tally_drop(l);
			stored_val[l] = b.val;
			written[l] = 1'b1;
			if (in_win)
				tally_add(l);
			return 1'b0;
		end
		// reversed bounds: dropping every element ends in a cleared histogram anyway
		if (l > r) begin
			window_clear();
			return 1'b1;
		end
		if (win_void) begin
			for (j = l; j <= r; j++)
				tally_add(j);
			win_lo = l;
			win_hi = r;
			win_void = 1'b0;
		end else begin
			while (win_hi < r) begin
				win_hi++;
				tally_add(win_hi);
			end
			while (win_lo > l) begin
				win_lo--;
				tally_add(win_lo);
			end
			while (win_hi > r) begin
				tally_drop(win_hi);
				win_hi--;
			end
			while (win_lo < l) begin
				tally_drop(win_lo);
				win_lo++;
			end
		end
		res = CNT_W'(live);
		return 1'b1;
	endfunction

	function automatic int clip(int x, int lo, int hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	// a window walk reads every entry between old and new bounds, so queries
	// stay inside the written run that holds the current window
	function automatic beat_t pick_beat();
		beat_t b;
		int roll;
		int a;
		int z;
		int p;
		int l;
		int r;
		int t;
		int k;
		b.mode = MODE_LOAD;
		b.pos = POS_W'($urandom_range(DEPTH - 1));
		b.rb = POS_W'($urandom);
		b.val = VAL_W'($urandom);
		roll = $urandom_range(99);
		p = -1;
		if (roll < 5) begin
			b.mode = MODE_QUERY;
			l = $urandom_range(DEPTH - 1, 1);
			b.pos = POS_W'(l);
			b.rb = POS_W'($urandom_range(l - 1, 0));
			return b;
		end
		if (roll >= 45) begin
			if (!win_void)
				p = win_lo;
			else
				for (t = 0; t < 8 && p < 0; t++) begin
					k = $urandom_range(DEPTH - 1);
					if (written[k])
						p = k;
				end
		end
		if (p < 0) begin
			k = $urandom_range(9);
			if (k < 4 && !win_void)
				p = $urandom_range(1) ? int'(win_hi) + 1 : int'(win_lo) - 1;
			else if (k < 7 && !win_void)
				p = $urandom_range(win_hi, win_lo);
			else
				p = $urandom_range(DEPTH - 1);
			b.pos = POS_W'(clip(p, 0, DEPTH - 1));
			k = $urandom_range(9);
			if (k < 7)
				b.val = VAL_W'($urandom_range(7));
			else if (k < 9)
				b.val = VAL_W'($urandom_range(63));
			else
				b.val = VAL_W'($urandom_range(SPAN - 1));
			return b;
		end
		a = p;
		z = p;
		while (a > 0 && written[a - 1])
			a--;
		while (z < DEPTH - 1 && written[z + 1])
			z++;
		b.mode = MODE_QUERY;
		if ($urandom_range(99) < 15) begin
			l = $urandom_range(z, a);
			r = $urandom_range(z, a);
		end else if (win_void) begin
			l = p - int'($urandom_range(16));
			r = p + int'($urandom_range(16));
		end else begin
			l = int'(win_lo) + int'($urandom_range(16)) - 8;
			r = int'(win_hi) + int'($urandom_range(16)) - 8;
		end
		l = clip(l, a, z);
		r = clip(r, a, z);
		if (l > r) begin
			t = l;
			l = r;
			r = t;
		end
		b.pos = POS_W'(l);
		b.rb = POS_W'(r);
		return b;
	endfunction

	// entered and left at a falling edge
	task automatic send_beat(beat_t b, logic fixed, logic [CNT_W-1:0] want);
		logic [CNT_W-1:0] got;
		while (!steady && $urandom_range(99) < GAP_PCT) begin
			push <= 1'b0;
			@(posedge clk);
			@(negedge clk);
		end
		push <= 1'b1;
		mode <= b.mode;
		position <= b.pos;
		right_bound <= b.rb;
		value_code <= b.val;
		@(posedge clk);
		while (full)
			@(posedge clk);
		if (predict_count(b, got))
			counts_due.insert(counts_due.size(), fixed ? want : got);
		@(negedge clk);
	endtask

	task automatic set_limit(logic [LIMIT_W-1:0] v);
		while (counts_due.size() != 0)
			@(negedge clk);
		// trailing loads may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_valid <= 1'b1;
		max_multiplicity <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cap = v;
		window_clear();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk)
		pop <= steady || ($urandom_range(99) >= GAP_PCT);

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (counts_due.size() == 0) begin
				report_mismatch($sformatf("count %0d with no query pending", count));
			end else begin
				due_count = counts_due.pop_front();
				if (count !== due_count)
					report_mismatch($sformatf("count %0d, expected %0d", count, due_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
			stall = 0;
		end else begin
			stall++;
			if (stall >= STALL_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		mode = MODE_LOAD;
		position = '0;
		right_bound = '0;
		value_code = '0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		max_multiplicity = LIMIT_RESET;
		errors = 0;
		stall = 0;
		steady = 1'b0;
		cap = LIMIT_RESET;
		window_clear();
		foreach (written[i]) begin
			written[i] = 1'b0;
			stored_val[i] = '0;
		end
		lim_seq = '{11'd0, 11'd1024, 11'd2047, 11'd2, 11'd1, 11'd3,
			LIMIT_W'($urandom_range(6, 1)), LIMIT_W'($urandom)};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (ROWS[i])
			send_beat(ROWS[i].beat, ROWS[i].fixed, ROWS[i].want);
		push <= 1'b0;

		for (int ph = 0; ph < PHASES; ph++) begin
			set_limit(lim_seq[ph]);
			steady = (ph == STEADY_PHASE);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_beat(pick_beat(), MODELED, '0);
			push <= 1'b0;
		end
		steady = 1'b0;

		while (counts_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
